/* hw/rtl/vcp_pkg.sv */
// Shared types, codes and helpers for the Verlet constraint step block.
package vcp_pkg;

  localparam int FRAC = 16;
  localparam logic signed [17:0] HALF = 18'sd32768;

  localparam logic [2:0] REQ_WR_POINT = 3'd0;
  localparam logic [2:0] REQ_WR_CON   = 3'd1;
  localparam logic [2:0] REQ_WR_LIM   = 3'd2;
  localparam logic [2:0] REQ_STEP     = 3'd3;
  localparam logic [2:0] REQ_RD_POINT = 3'd4;

  localparam logic [2:0] CFG_GRAV_X  = 3'd0;
  localparam logic [2:0] CFG_GRAV_Y  = 3'd1;
  localparam logic [2:0] CFG_GRAV_Z  = 3'd2;
  localparam logic [2:0] CFG_PASSES  = 3'd3;
  localparam logic [2:0] CFG_NPOINT  = 3'd4;
  localparam logic [2:0] CFG_NCON    = 3'd5;
  localparam logic [2:0] CFG_NLIM    = 3'd6;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [2:0] vec_t;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [5:0]          index;
    logic signed [31:0]  cur_x;
    logic signed [31:0]  cur_y;
    logic signed [31:0]  cur_z;
    logic signed [31:0]  prev_x;
    logic signed [31:0]  prev_y;
    logic signed [31:0]  prev_z;
    logic [5:0]          point_a;
    logic [5:0]          point_b;
    logic [30:0]         amount;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [5:0]          echo_index;
    logic signed [31:0]  out_cur_x;
    logic signed [31:0]  out_cur_y;
    logic signed [31:0]  out_cur_z;
    logic signed [31:0]  out_prev_x;
    logic signed [31:0]  out_prev_y;
    logic signed [31:0]  out_prev_z;
  } res_t;

  typedef struct packed {
    logic [5:0]  a;
    logic [5:0]  b;
    logic [30:0] rest;
  } con_t;

  typedef struct packed {
    logic [5:0]  pt;
    logic [30:0] cap;
  } lim_t;

  typedef struct packed {
    logic start;
    logic sqrt;
  } iter_req_t;

  function automatic coord_t sat32(input logic signed [63:0] v);
    coord_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/vcp_mul.sv */
// Shared registered signed multiplier.
module vcp_mul import vcp_pkg::*; (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  logic signed [67:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 68'(a_i) * 68'(b_i);
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/vcp_iter.sv */
// Bit-serial unit: 64/64 restoring divide or 64-bit integer square root.
module vcp_iter import vcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  iter_req_t   req_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] q_o
);

  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  logic        run_q, done_q, sq_q;
  logic [6:0]  cnt_q;
  logic [63:0] x_q, d_q, q_q;
  logic [64:0] rem_q;
  logic [65:0] rem_sh, trial, rem_d;
  logic        ge;

  always_comb begin
    if (sq_q) begin
      rem_sh = {rem_q[63:0], x_q[63:62]};
      trial  = {q_q, 2'b01};
    end else begin
      rem_sh = {rem_q, x_q[63]};
      trial  = {2'b00, d_q};
    end
    ge    = (rem_sh >= trial);
    rem_d = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= req_i.sqrt ? SQRT_STEPS : DIV_STEPS;
      end else if (run_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sq_q  <= req_i.sqrt;
      x_q   <= a_i;
      d_q   <= b_i;
      rem_q <= '0;
      q_q   <= '0;
    end else if (run_q) begin
      rem_q <= rem_d[64:0];
      q_q   <= {q_q[62:0], ge};
      x_q   <= sq_q ? {x_q[61:0], 2'b00} : {x_q[62:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

/* hw/rtl/verlet_constraint_physics_step_top.sv */
// Top level: request decode, tables, and the step sequencer.
//
// Usage:
//  - Request channel: drive req_i and raise start_i; the request is taken
//    at a clock edge where start_i is high and busy_o is low.
//  - Result channel: res_valid_o pulses for one cycle with res_o; there is
//    no back-pressure, the receiver must take it in that cycle.
//  - Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i/cfg_data_i;
//    ready is always high. Write registers only while the block is idle.
//  - Table writes and refused requests answer in the cycle after the request;
//    a point read first goes through the registered table read and S_READ.
//  - A step runs on one shared multiplier and one bit-serial divide/sqrt
//    unit: per pass, at most one divide per constraint; per limit, one root
//    and, if capped, one divide per axis. Constraints and limits that name
//    a point beyond the point count are skipped. busy_o is high for the
//    whole step and only one request is in flight at a time.
//  - Reset clears configuration to defaults and the sequencer to idle;
//    table contents are undefined until written.
module verlet_constraint_physics_step_top import vcp_pkg::*; #(
  parameter int MAX_POINTS      = 64,
  parameter int MAX_CONSTRAINTS = 64,
  parameter int MAX_LIMITS      = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int PW  = $clog2(MAX_POINTS + 1);
  localparam int CW  = $clog2(MAX_CONSTRAINTS + 1);
  localparam int LW  = $clog2(MAX_LIMITS + 1);
  localparam int IW  = (PW > CW) ? ((PW > LW) ? PW : LW) : ((CW > LW) ? CW : LW);
  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CAW = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
  localparam int LAW = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1;

  typedef enum logic [22:0] {
    S_IDLE = 23'd1 << 0,  S_READ = 23'd1 << 1,  S_GMUL = 23'd1 << 2,
    S_MRD  = 23'd1 << 3,  S_MUPD = 23'd1 << 4,  S_RRD  = 23'd1 << 5,
    S_RCHK = 23'd1 << 6,  S_RLA  = 23'd1 << 7,  S_RLB  = 23'd1 << 8,
    S_RSQ  = 23'd1 << 9,  S_RDIV = 23'd1 << 10, S_RCOR = 23'd1 << 11,
    S_RWA  = 23'd1 << 12, S_RWB  = 23'd1 << 13, S_LRD  = 23'd1 << 14,
    S_LCHK = 23'd1 << 15, S_LLD  = 23'd1 << 16, S_LSQ  = 23'd1 << 17,
    S_LRT  = 23'd1 << 18, S_LMUL = 23'd1 << 19, S_LDIV = 23'd1 << 20,
    S_LWR  = 23'd1 << 21, S_DONE = 23'd1 << 22
  } state_e;

  state_e state_q, state_d;

  // configuration
  coord_t     grav_q [3];
  logic [2:0] passes_q;
  logic [6:0] npoint_q, ncon_q, nlim_q;

  // sequencer counters
  logic [IW-1:0] i_q, i_d, i_nx;
  logic [1:0]    k_q, k_d;
  logic          ph_q, ph_d;
  logic [2:0]    pass_q, pass_d;

  // results
  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  // tables
  vec_t cur_mem  [MAX_POINTS];
  vec_t prev_mem [MAX_POINTS];
  con_t con_mem  [MAX_CONSTRAINTS];
  lim_t lim_mem  [MAX_LIMITS];

  logic           cur_we, cur_re, prev_we, prev_re, con_we, con_re, lim_we, lim_re;
  logic [AW-1:0]  cur_wa, cur_ra, prev_wa, prev_ra;
  logic [CAW-1:0] con_ra;
  logic [LAW-1:0] lim_ra;
  vec_t           cur_wd, prev_wd, cur_rd_q, prev_rd_q;
  con_t           con_rd_q;
  lim_t           lim_rd_q;

  // datapath
  logic [30:0]        amt_q;
  logic signed [47:0] g_q [3];
  vec_t               ca_q, cb_q, d_q, pv_q;
  logic [47:0]        dd_q, rr_q, den;
  logic signed [17:0] f_q;
  logic [63:0]        ss_q, prod_q;
  logic [31:0]        mag_q, exc_q;

  // shared units
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  iter_req_t          it_req;
  logic [63:0]        it_a, it_b, it_q;
  logic               it_done;

  vcp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  vcp_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (it_req),
    .a_i    (it_a),
    .b_i    (it_b),
    .done_o (it_done),
    .q_o    (it_q)
  );

  // clamped counts
  logic [IW-1:0] np_w, nc_w, nl_w;
  assign np_w = (32'(npoint_q) > MAX_POINTS)      ? IW'(MAX_POINTS)      : IW'(npoint_q);
  assign nc_w = (32'(ncon_q)   > MAX_CONSTRAINTS) ? IW'(MAX_CONSTRAINTS) : IW'(ncon_q);
  assign nl_w = (32'(nlim_q)   > MAX_LIMITS)      ? IW'(MAX_LIMITS)      : IW'(nlim_q);
  assign i_nx = i_q + IW'(1);

  // next-hop targets shared by several states
  state_e after_relax_st, after_move_st, rn_state, ln_state;
  logic [IW-1:0] rn_i, ln_i;
  logic [2:0]    rn_pass;
  logic          relax_go;

  assign relax_go       = (passes_q != 3'd0) && (nc_w != '0);
  assign after_relax_st = (nl_w != '0) ? S_LRD : S_DONE;
  assign after_move_st  = relax_go ? S_RRD : after_relax_st;

  always_comb begin
    rn_i    = '0;
    rn_pass = pass_q;
    if (i_nx < nc_w) begin
      rn_state = S_RRD;
      rn_i     = i_nx;
    end else if (({1'b0, pass_q} + 4'd1) < {1'b0, passes_q}) begin
      rn_state = S_RRD;
      rn_pass  = pass_q + 3'd1;
    end else begin
      rn_state = after_relax_st;
    end
    if (i_nx < nl_w) begin
      ln_state = S_LRD;
      ln_i     = i_nx;
    end else begin
      ln_state = S_DONE;
      ln_i     = '0;
    end
  end

  // skip tests for dangling references
  logic con_skip, lim_skip;
  assign con_skip = (32'(con_rd_q.a) >= 32'(np_w)) || (32'(con_rd_q.b) >= 32'(np_w));
  assign lim_skip = (32'(lim_rd_q.pt) >= 32'(np_w));

  // Verlet move of the point just read
  vec_t mv_new;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mv_new[k] = sat32(64'(cur_rd_q[k]) + 64'(cur_rd_q[k]) - 64'(prev_rd_q[k])
                        + 64'(g_q[k]));
    end
  end

  // per-axis values for the speed cap
  logic [31:0]        m_abs;
  logic signed [63:0] adj_s;
  assign m_abs = d_q[k_q][31] ? (32'(~d_q[k_q]) + 32'd1) : 32'(d_q[k_q]);
  assign adj_s = d_q[k_q][31] ? -$signed({32'b0, it_q[31:0]}) : $signed({32'b0, it_q[31:0]});

  logic signed [67:0] c_sh;
  assign c_sh = mul_p >>> FRAC;
  assign den  = dd_q + rr_q;

  logic in_pt, in_con, in_lim;
  assign in_pt  = 32'(req_i.index) < MAX_POINTS;
  assign in_con = 32'(req_i.index) < MAX_CONSTRAINTS;
  assign in_lim = 32'(req_i.index) < MAX_LIMITS;

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d = i_q; k_d = k_q; ph_d = ph_q; pass_d = pass_q;
    res_d = res_q; res_valid_d = 1'b0;
    cur_we = 1'b0; cur_wa = '0; cur_wd = '0; cur_re = 1'b0; cur_ra = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0; prev_re = 1'b0; prev_ra = '0;
    con_we = 1'b0; con_re = 1'b0; con_ra = '0;
    lim_we = 1'b0; lim_re = 1'b0; lim_ra = '0;
    mul_a = '0; mul_b = '0;
    it_req = '0; it_a = '0; it_b = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d = '0;
          res_d.echo_index = req_i.index;
          if (req_i.req_type == REQ_WR_POINT) begin
            res_valid_d = 1'b1;
            res_d.status = !in_pt;
            cur_we  = in_pt;
            prev_we = in_pt;
            cur_wa  = AW'(req_i.index);
            prev_wa = AW'(req_i.index);
            cur_wd  = {req_i.cur_z, req_i.cur_y, req_i.cur_x};
            prev_wd = {req_i.prev_z, req_i.prev_y, req_i.prev_x};
          end else if (req_i.req_type == REQ_WR_CON) begin
            res_valid_d = 1'b1;
            res_d.status = !in_con;
            con_we = in_con;
          end else if (req_i.req_type == REQ_WR_LIM) begin
            res_valid_d = 1'b1;
            res_d.status = !in_lim;
            lim_we = in_lim;
          end else if (req_i.req_type == REQ_STEP) begin
            res_d.echo_index = '0;
            state_d = S_GMUL;
            k_d = '0;
            ph_d = 1'b0;
          end else if (req_i.req_type == REQ_RD_POINT) begin
            if (in_pt) begin
              cur_re  = 1'b1;
              prev_re = 1'b1;
              cur_ra  = AW'(req_i.index);
              prev_ra = AW'(req_i.index);
              state_d = S_READ;
            end else begin
              res_valid_d = 1'b1;
              res_d.status = 1'b1;
            end
          end else begin
            res_valid_d = 1'b1;
          end
        end
      end
      S_READ: begin
        res_valid_d = 1'b1;
        res_d.out_cur_x  = cur_rd_q[0];
        res_d.out_cur_y  = cur_rd_q[1];
        res_d.out_cur_z  = cur_rd_q[2];
        res_d.out_prev_x = prev_rd_q[0];
        res_d.out_prev_y = prev_rd_q[1];
        res_d.out_prev_z = prev_rd_q[2];
        state_d = S_IDLE;
      end
      S_GMUL: begin
        mul_a = 34'(grav_q[k_q]);
        mul_b = 34'(amt_q);
        ph_d  = !ph_q;
        if (ph_q) begin
          if (k_q == 2'd2) begin
            k_d = '0;
            i_d = '0;
            pass_d = '0;
            state_d = (np_w != '0) ? S_MRD : after_move_st;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      S_MRD: begin
        cur_re  = 1'b1;
        prev_re = 1'b1;
        cur_ra  = AW'(i_q);
        prev_ra = AW'(i_q);
        state_d = S_MUPD;
      end
      S_MUPD: begin
        cur_we  = 1'b1;
        prev_we = 1'b1;
        cur_wa  = AW'(i_q);
        prev_wa = AW'(i_q);
        cur_wd  = mv_new;
        prev_wd = cur_rd_q;
        if (i_nx < np_w) begin
          i_d = i_nx;
          state_d = S_MRD;
        end else begin
          i_d = '0;
          pass_d = '0;
          state_d = after_move_st;
        end
      end
      S_RRD: begin
        con_re = 1'b1;
        con_ra = CAW'(i_q);
        state_d = S_RCHK;
      end
      S_RCHK: begin
        if (con_skip) begin
          state_d = rn_state;
          i_d = rn_i;
          pass_d = rn_pass;
        end else begin
          cur_re = 1'b1;
          cur_ra = AW'(con_rd_q.a);
          state_d = S_RLA;
        end
      end
      S_RLA: begin
        cur_re = 1'b1;
        cur_ra = AW'(con_rd_q.b);
        state_d = S_RLB;
      end
      S_RLB: begin
        k_d = '0;
        ph_d = 1'b0;
        state_d = S_RSQ;
      end
      S_RSQ: begin
        if (k_q == 2'd3) begin
          mul_a = 34'(con_rd_q.rest);
          mul_b = 34'(con_rd_q.rest);
        end else begin
          mul_a = 34'(d_q[k_q]);
          mul_b = 34'(d_q[k_q]);
        end
        ph_d = !ph_q;
        if (ph_q) begin
          k_d = k_q + 2'd1;
          if (k_q == 2'd3) begin
            state_d = S_RDIV;
          end
        end
      end
      S_RDIV: begin
        it_a = {rr_q, FRAC'(0)};
        it_b = 64'(den);
        if (!ph_q) begin
          if (den == '0) begin
            state_d = S_RCOR;
            k_d = '0;
          end else begin
            it_req.start = 1'b1;
            ph_d = 1'b1;
          end
        end else if (it_done) begin
          ph_d = 1'b0;
          k_d = '0;
          state_d = S_RCOR;
        end
      end
      S_RCOR: begin
        mul_a = 34'(d_q[k_q]);
        mul_b = 34'(f_q);
        ph_d  = !ph_q;
        if (ph_q) begin
          if (k_q == 2'd2) begin
            k_d = '0;
            state_d = S_RWA;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      S_RWA: begin
        cur_we = 1'b1;
        cur_wa = AW'(con_rd_q.a);
        cur_wd = ca_q;
        state_d = S_RWB;
      end
      S_RWB: begin
        cur_we = 1'b1;
        cur_wa = AW'(con_rd_q.b);
        cur_wd = cb_q;
        state_d = rn_state;
        i_d = rn_i;
        pass_d = rn_pass;
      end
      S_LRD: begin
        lim_re = 1'b1;
        lim_ra = LAW'(i_q);
        state_d = S_LCHK;
      end
      S_LCHK: begin
        if (lim_skip) begin
          state_d = ln_state;
          i_d = ln_i;
        end else begin
          cur_re  = 1'b1;
          prev_re = 1'b1;
          cur_ra  = AW'(lim_rd_q.pt);
          prev_ra = AW'(lim_rd_q.pt);
          state_d = S_LLD;
        end
      end
      S_LLD: begin
        k_d = '0;
        ph_d = 1'b0;
        state_d = S_LSQ;
      end
      S_LSQ: begin
        mul_a = 34'(d_q[k_q]);
        mul_b = 34'(d_q[k_q]);
        ph_d  = !ph_q;
        if (ph_q) begin
          if (k_q == 2'd2) begin
            k_d = '0;
            state_d = S_LRT;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      S_LRT: begin
        it_a = ss_q;
        it_req.sqrt = 1'b1;
        if (!ph_q) begin
          it_req.start = 1'b1;
          ph_d = 1'b1;
        end else if (it_done) begin
          ph_d = 1'b0;
          if (it_q[31:0] > {1'b0, lim_rd_q.cap}) begin
            k_d = '0;
            state_d = S_LMUL;
          end else begin
            state_d = ln_state;
            i_d = ln_i;
          end
        end
      end
      S_LMUL: begin
        mul_a = 34'(m_abs);
        mul_b = 34'(exc_q);
        ph_d  = !ph_q;
        if (ph_q) begin
          state_d = S_LDIV;
        end
      end
      S_LDIV: begin
        it_a = prod_q;
        it_b = 64'(mag_q);
        if (!ph_q) begin
          it_req.start = 1'b1;
          ph_d = 1'b1;
        end else if (it_done) begin
          ph_d = 1'b0;
          if (k_q == 2'd2) begin
            k_d = '0;
            state_d = S_LWR;
          end else begin
            k_d = k_q + 2'd1;
            state_d = S_LMUL;
          end
        end
      end
      S_LWR: begin
        prev_we = 1'b1;
        prev_wa = AW'(lim_rd_q.pt);
        prev_wd = pv_q;
        state_d = ln_state;
        i_d = ln_i;
      end
      S_DONE: begin
        res_d = '0;
        res_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      k_q         <= '0;
      ph_q        <= 1'b0;
      pass_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      k_q         <= k_d;
      ph_q        <= ph_d;
      pass_q      <= pass_d;
      res_valid_q <= res_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0] <= '0;
      grav_q[1] <= '0;
      grav_q[2] <= '0;
      passes_q  <= 3'd3;
      npoint_q  <= '0;
      ncon_q    <= '0;
      nlim_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GRAV_X: grav_q[0] <= cfg_data_i;
        CFG_GRAV_Y: grav_q[1] <= cfg_data_i;
        CFG_GRAV_Z: grav_q[2] <= cfg_data_i;
        CFG_PASSES: passes_q  <= cfg_data_i[2:0];
        CFG_NPOINT: npoint_q  <= cfg_data_i[6:0];
        CFG_NCON:   ncon_q    <= cfg_data_i[6:0];
        CFG_NLIM:   nlim_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // table storage, registered reads
  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    if (cur_re) cur_rd_q <= cur_mem[cur_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd_q <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk_i) begin
    if (con_we) con_mem[CAW'(req_i.index)] <= '{a: req_i.point_a, b: req_i.point_b,
                                                rest: req_i.amount};
    if (con_re) con_rd_q <= con_mem[con_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lim_we) lim_mem[LAW'(req_i.index)] <= '{pt: req_i.point_a, cap: req_i.amount};
    if (lim_re) lim_rd_q <= lim_mem[lim_ra];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    unique case (state_q)
      S_IDLE: begin
        amt_q <= req_i.amount;
      end
      S_GMUL: begin
        if (ph_q) g_q[k_q] <= 48'(c_sh);
      end
      S_RLA: begin
        ca_q <= cur_rd_q;
      end
      S_RLB: begin
        cb_q <= cur_rd_q;
        for (int k = 0; k < 3; k++) begin
          d_q[k] <= sat32(64'(cur_rd_q[k]) - 64'(ca_q[k]));
        end
        dd_q <= '0;
      end
      S_RSQ: begin
        if (ph_q) begin
          if (k_q == 2'd3) rr_q <= mul_p[FRAC+47:FRAC];
          else             dd_q <= dd_q + mul_p[FRAC+47:FRAC];
        end
      end
      S_RDIV: begin
        if (!ph_q && den == '0) begin
          f_q <= '0;
        end else if (ph_q && it_done) begin
          f_q <= $signed({1'b0, it_q[16:0]}) - HALF;
        end
      end
      S_RCOR: begin
        if (ph_q) begin
          ca_q[k_q] <= sat32(64'(ca_q[k_q]) - 64'(c_sh));
          cb_q[k_q] <= sat32(64'(cb_q[k_q]) + 64'(c_sh));
        end
      end
      S_LLD: begin
        pv_q <= prev_rd_q;
        for (int k = 0; k < 3; k++) begin
          d_q[k] <= sat32(64'(cur_rd_q[k]) - 64'(prev_rd_q[k]));
        end
        ss_q <= '0;
      end
      S_LSQ: begin
        if (ph_q) ss_q <= ss_q + mul_p[63:0];
      end
      S_LRT: begin
        if (ph_q && it_done) begin
          mag_q <= it_q[31:0];
          exc_q <= it_q[31:0] - {1'b0, lim_rd_q.cap};
        end
      end
      S_LMUL: begin
        if (ph_q) prod_q <= mul_p[63:0];
      end
      S_LDIV: begin
        if (ph_q && it_done) pv_q[k_q] <= sat32(64'(pv_q[k_q]) + adj_s);
      end
      default: ;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

endmodule
